>>> rtl/mpbm_pkg.sv
// ----------------------------------------------------------------------------
// mpbm_pkg
// Shared types and constants of the multi-pattern byte matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mpbm_pkg;

  localparam int NODE_W    = 10;
  localparam int MAX_NODES = 1024;
  localparam int SYM_W     = 8;
  localparam int ALPHABET  = 256;
  localparam int ID_W      = 8;
  localparam int CNT_W     = NODE_W + 1;
  localparam int GOTO_AW   = NODE_W + SYM_W;
  localparam int GOTO_DEPTH = MAX_NODES * ALPHABET;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_FIN   = 2'd1;
  localparam logic [1:0] KIND_BEGIN = 2'd2;
  localparam logic [1:0] KIND_SCAN  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_REPL = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SYM_W-1:0] byte_value;
    logic             last_of_pattern;
    logic [ID_W-1:0]  pattern_id;
  } in_t;

  typedef struct packed {
    logic              match;
    logic [ID_W-1:0]   matched_id;
    logic [NODE_W-1:0] node_index;
    logic [1:0]        status;
  } out_t;

  // Access to the goto memory: one write, one read, and a row clear request.
  typedef struct packed {
    logic               we;
    logic [GOTO_AW-1:0] waddr;
    logic [NODE_W-1:0]  wdata;
    logic [GOTO_AW-1:0] raddr;
    logic               clr_start;
    logic [NODE_W-1:0]  clr_row;
  } goto_req_t;

endpackage

`default_nettype wire

>>> rtl/mpbm_trie_mem.sv
// ----------------------------------------------------------------------------
// mpbm_trie_mem
// Goto memory of the trie with a row clear engine (one entry per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module mpbm_trie_mem (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mpbm_pkg::goto_req_t         req,
  output logic [mpbm_pkg::NODE_W-1:0]      rdata,
  output logic                             clr_busy
);

  logic [mpbm_pkg::NODE_W-1:0] mem [0:mpbm_pkg::GOTO_DEPTH-1];
  logic [mpbm_pkg::NODE_W-1:0] rdata_r;
  logic                        active_r;
  logic [mpbm_pkg::NODE_W-1:0] row_r;
  logic [mpbm_pkg::SYM_W-1:0]  col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (req.clr_start) begin
      active_r <= 1'b1;
    end else if (active_r && col_r == mpbm_pkg::SYM_W'(mpbm_pkg::ALPHABET - 1)) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.clr_start) begin
      row_r <= req.clr_row;
      col_r <= '0;
    end else if (active_r) begin
      col_r <= col_r + 1'b1;
    end
  end

  // Clear sweep owns the write port while active.
  always_ff @(posedge clk) begin
    if (active_r) begin
      mem[{row_r, col_r}] <= '0;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata    = rdata_r;
  assign clr_busy = active_r;

endmodule

`default_nettype wire

>>> rtl/multi_pattern_byte_matcher.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher
// Aho-Corasick byte matcher with the trie, failure links and terminal marks
// held in synchronous node memories.
// ----------------------------------------------------------------------------
// Usage: raise start with an item while busy is low; every item gives exactly
// one result, shown for one cycle with out_valid high, and the receiver cannot
// stall it. One item is worked on at a time, and every memory read is
// registered. Begin search: result in the next cycle, busy stays low. Add
// pattern byte: a goto read, then a terminal-mark read and write when the byte
// ends a pattern; when a node is allocated the block waits while the new node's
// 256-entry goto row is cleared one entry per cycle. Scan byte: a goto read,
// a failure-link read and a goto read per failure link followed, then a
// terminal-mark read. Finalize: each root row entry is read in turn, then per
// trie node a queue read, a failure-link read and a read of each of its 256
// goto entries, with a failure walk for each child. After reset the block is
// busy while the root's goto row is cleared. Symbol edges back to the root
// created by finalize are not stored: a missing root edge acts the same.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_byte_matcher (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire mpbm_pkg::in_t  in_item,
  output logic                out_valid,
  output mpbm_pkg::out_t      out_item
);

  localparam int NW = mpbm_pkg::NODE_W;
  localparam int SW = mpbm_pkg::SYM_W;

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_INITW   = 5'd1;
  localparam logic [4:0] S_IDLE    = 5'd2;
  localparam logic [4:0] S_ADD_EV  = 5'd3;
  localparam logic [4:0] S_ADD_CLR = 5'd4;
  localparam logic [4:0] S_TAIL    = 5'd5;
  localparam logic [4:0] S_TERM_EV = 5'd6;
  localparam logic [4:0] S_W_EV    = 5'd7;
  localparam logic [4:0] S_W_FAIL  = 5'd8;
  localparam logic [4:0] S_SC_TERM = 5'd9;
  localparam logic [4:0] S_FIN_RRD = 5'd10;
  localparam logic [4:0] S_FIN_REV = 5'd11;
  localparam logic [4:0] S_FQ_RD   = 5'd12;
  localparam logic [4:0] S_FQ_R    = 5'd13;
  localparam logic [4:0] S_FQ_F    = 5'd14;
  localparam logic [4:0] S_FB_RD   = 5'd15;
  localparam logic [4:0] S_FB_EV   = 5'd16;

  localparam logic [SW-1:0] LAST_SYM = SW'(mpbm_pkg::ALPHABET - 1);

  // Control registers
  logic [4:0]               state_r, state_nxt;
  logic [mpbm_pkg::CNT_W-1:0] nodes_r, nodes_nxt;
  logic [NW-1:0]            ins_r, ins_nxt;
  logic [NW-1:0]            scn_r, scn_nxt;
  logic                     out_valid_r, emit;

  // Working registers
  mpbm_pkg::in_t            cmd_r, cmd_nxt;
  mpbm_pkg::out_t           out_r, emit_d;
  logic [NW-1:0]            cur_r, cur_nxt;
  logic                     ok_r, ok_nxt;
  logic [1:0]               status_r, status_nxt;
  logic [NW-1:0]            walk_r, walk_nxt;
  logic [SW-1:0]            wsym_r, wsym_nxt;
  logic                     fin_walk_r, fin_walk_nxt;
  logic [NW-1:0]            tgt_r, tgt_nxt;
  logic [NW-1:0]            e_r, e_nxt;
  logic [NW-1:0]            r_r, r_nxt;
  logic [NW-1:0]            fr_r, fr_nxt;
  logic [SW-1:0]            cnt_r, cnt_nxt;
  logic [NW-1:0]            head_r, head_nxt;
  logic [NW-1:0]            tail_r, tail_nxt;

  // Memories
  mpbm_pkg::goto_req_t      greq;
  logic [NW-1:0]            goto_rdata;
  logic                     clr_busy;

  logic [NW-1:0]            fail_mem [0:mpbm_pkg::MAX_NODES-1];
  logic                     fail_we;
  logic [NW-1:0]            fail_waddr, fail_wdata, fail_raddr, fail_rdata_r;

  logic [mpbm_pkg::ID_W:0]  term_mem [0:mpbm_pkg::MAX_NODES-1];
  logic                     term_we;
  logic [NW-1:0]            term_waddr, term_raddr;
  logic [mpbm_pkg::ID_W:0]  term_wdata, term_rdata_r;

  logic [NW-1:0]            bfsq_mem [0:mpbm_pkg::MAX_NODES-1];
  logic                     bfsq_we;
  logic [NW-1:0]            bfsq_waddr, bfsq_wdata, bfsq_raddr, bfsq_rdata_r;

  mpbm_trie_mem u_trie (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (greq),
    .rdata    (goto_rdata),
    .clr_busy (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (fail_we) begin
      fail_mem[fail_waddr] <= fail_wdata;
    end
    fail_rdata_r <= fail_mem[fail_raddr];
  end

  always_ff @(posedge clk) begin
    if (term_we) begin
      term_mem[term_waddr] <= term_wdata;
    end
    term_rdata_r <= term_mem[term_raddr];
  end

  always_ff @(posedge clk) begin
    if (bfsq_we) begin
      bfsq_mem[bfsq_waddr] <= bfsq_wdata;
    end
    bfsq_rdata_r <= bfsq_mem[bfsq_raddr];
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    logic adv;
    logic m;
    adv          = 1'b0;
    m            = 1'b0;
    state_nxt    = state_r;
    nodes_nxt    = nodes_r;
    ins_nxt      = ins_r;
    scn_nxt      = scn_r;
    cmd_nxt      = cmd_r;
    cur_nxt      = cur_r;
    ok_nxt       = ok_r;
    status_nxt   = status_r;
    walk_nxt     = walk_r;
    wsym_nxt     = wsym_r;
    fin_walk_nxt = fin_walk_r;
    tgt_nxt      = tgt_r;
    e_nxt        = e_r;
    r_nxt        = r_r;
    fr_nxt       = fr_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    emit         = 1'b0;
    emit_d       = '0;
    greq         = '0;
    fail_we      = 1'b0;
    fail_waddr   = '0;
    fail_wdata   = '0;
    fail_raddr   = '0;
    term_we      = 1'b0;
    term_waddr   = '0;
    term_wdata   = '0;
    term_raddr   = '0;
    bfsq_we      = 1'b0;
    bfsq_waddr   = '0;
    bfsq_wdata   = '0;
    bfsq_raddr   = '0;

    case (state_r)
      S_INIT: begin
        greq.clr_start = 1'b1;
        greq.clr_row   = '0;
        state_nxt      = S_INITW;
      end
      S_INITW: begin
        if (!clr_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_item;
          status_nxt = mpbm_pkg::ST_OK;
          ok_nxt     = 1'b0;
          case (in_item.kind)
            mpbm_pkg::KIND_ADD: begin
              greq.raddr = {ins_r, in_item.byte_value};
              cur_nxt    = ins_r;
              state_nxt  = S_ADD_EV;
            end
            mpbm_pkg::KIND_FIN: begin
              cnt_nxt   = '0;
              head_nxt  = '0;
              tail_nxt  = '0;
              state_nxt = S_FIN_RRD;
            end
            mpbm_pkg::KIND_BEGIN: begin
              scn_nxt = '0;
              emit    = 1'b1;
            end
            default: begin
              walk_nxt     = scn_r;
              wsym_nxt     = in_item.byte_value;
              fin_walk_nxt = 1'b0;
              greq.raddr   = {scn_r, in_item.byte_value};
              state_nxt    = S_W_EV;
            end
          endcase
        end
      end
      S_ADD_EV: begin
        if (goto_rdata != '0) begin
          cur_nxt   = goto_rdata;
          ok_nxt    = 1'b1;
          state_nxt = S_TAIL;
        end else if (nodes_r != mpbm_pkg::CNT_W'(mpbm_pkg::MAX_NODES)) begin
          // Allocate: link the edge, reset the node's words, clear its row.
          greq.we        = 1'b1;
          greq.waddr     = {cur_r, cmd_r.byte_value};
          greq.wdata     = nodes_r[NW-1:0];
          greq.clr_start = 1'b1;
          greq.clr_row   = nodes_r[NW-1:0];
          fail_we        = 1'b1;
          fail_waddr     = nodes_r[NW-1:0];
          term_we        = 1'b1;
          term_waddr     = nodes_r[NW-1:0];
          nodes_nxt      = nodes_r + 1'b1;
          cur_nxt        = nodes_r[NW-1:0];
          ok_nxt         = 1'b1;
          state_nxt      = S_ADD_CLR;
        end else begin
          status_nxt = mpbm_pkg::ST_FULL;
          state_nxt  = S_TAIL;
        end
      end
      S_ADD_CLR: begin
        if (!clr_busy) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        if (cmd_r.last_of_pattern && ok_r) begin
          term_raddr = cur_r;
          state_nxt  = S_TERM_EV;
        end else begin
          ins_nxt           = cmd_r.last_of_pattern ? '0 : cur_r;
          emit              = 1'b1;
          emit_d.node_index = cmd_r.last_of_pattern ? '0 : cur_r;
          emit_d.status     = status_r;
          state_nxt         = S_IDLE;
        end
      end
      S_TERM_EV: begin
        term_we       = 1'b1;
        term_waddr    = cur_r;
        term_wdata    = {1'b1, cmd_r.pattern_id};
        ins_nxt       = '0;
        emit          = 1'b1;
        emit_d.status = term_rdata_r[mpbm_pkg::ID_W] ? mpbm_pkg::ST_REPL : status_r;
        state_nxt     = S_IDLE;
      end
      S_W_EV: begin
        if (goto_rdata != '0 || walk_r == '0) begin
          if (fin_walk_r) begin
            fail_we    = 1'b1;
            fail_waddr = e_r;
            fail_wdata = goto_rdata;
            adv        = 1'b1;
          end else begin
            tgt_nxt    = goto_rdata;
            term_raddr = goto_rdata;
            state_nxt  = S_SC_TERM;
          end
        end else begin
          fail_raddr = walk_r;
          state_nxt  = S_W_FAIL;
        end
      end
      S_W_FAIL: begin
        walk_nxt   = fail_rdata_r;
        greq.raddr = {fail_rdata_r, wsym_r};
        state_nxt  = S_W_EV;
      end
      S_SC_TERM: begin
        // The root is never terminal.
        m                 = (tgt_r != '0) && term_rdata_r[mpbm_pkg::ID_W];
        scn_nxt           = tgt_r;
        emit              = 1'b1;
        emit_d.match      = m;
        emit_d.matched_id = m ? term_rdata_r[mpbm_pkg::ID_W-1:0] : '0;
        emit_d.node_index = tgt_r;
        state_nxt         = S_IDLE;
      end
      S_FIN_RRD: begin
        greq.raddr = {NW'(0), cnt_r};
        state_nxt  = S_FIN_REV;
      end
      S_FIN_REV: begin
        if (goto_rdata != '0) begin
          bfsq_we    = 1'b1;
          bfsq_waddr = tail_r;
          bfsq_wdata = goto_rdata;
          tail_nxt   = tail_r + 1'b1;
          fail_we    = 1'b1;
          fail_waddr = goto_rdata;
        end
        if (cnt_r == LAST_SYM) begin
          state_nxt = S_FQ_RD;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_FIN_RRD;
        end
      end
      S_FQ_RD: begin
        if (head_r == tail_r) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          bfsq_raddr = head_r;
          head_nxt   = head_r + 1'b1;
          state_nxt  = S_FQ_R;
        end
      end
      S_FQ_R: begin
        r_nxt      = bfsq_rdata_r;
        fail_raddr = bfsq_rdata_r;
        state_nxt  = S_FQ_F;
      end
      S_FQ_F: begin
        fr_nxt    = fail_rdata_r;
        cnt_nxt   = '0;
        state_nxt = S_FB_RD;
      end
      S_FB_RD: begin
        greq.raddr = {r_r, cnt_r};
        state_nxt  = S_FB_EV;
      end
      S_FB_EV: begin
        if (goto_rdata == '0) begin
          adv = 1'b1;
        end else begin
          bfsq_we      = 1'b1;
          bfsq_waddr   = tail_r;
          bfsq_wdata   = goto_rdata;
          tail_nxt     = tail_r + 1'b1;
          e_nxt        = goto_rdata;
          walk_nxt     = fr_r;
          wsym_nxt     = cnt_r;
          fin_walk_nxt = 1'b1;
          greq.raddr   = {fr_r, cnt_r};
          state_nxt    = S_W_EV;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase

    // Advance to the next symbol of the node being expanded.
    if (adv) begin
      if (cnt_r == LAST_SYM) begin
        state_nxt = S_FQ_RD;
      end else begin
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_FB_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      nodes_r     <= mpbm_pkg::CNT_W'(1);
      ins_r       <= '0;
      scn_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nodes_r     <= nodes_nxt;
      ins_r       <= ins_nxt;
      scn_r       <= scn_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_r      <= emit_d;
    cur_r      <= cur_nxt;
    ok_r       <= ok_nxt;
    status_r   <= status_nxt;
    walk_r     <= walk_nxt;
    wsym_r     <= wsym_nxt;
    fin_walk_r <= fin_walk_nxt;
    tgt_r      <= tgt_nxt;
    e_r        <= e_nxt;
    r_r        <= r_nxt;
    fr_r       <= fr_nxt;
    cnt_r      <= cnt_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Any transfer other than begin search keeps the block busy next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind != mpbm_pkg::KIND_BEGIN) |=> busy)
    else $error("busy did not rise after an accepted item");

  // A match always lands on a non-root node.
  a_match_nonroot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.match) |-> (out_item.node_index != '0))
    else $error("match reported on the root node");

  // The node count stays within the table.
  a_nodes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_r <= mpbm_pkg::CNT_W'(mpbm_pkg::MAX_NODES))
    else $error("node count beyond table size");

  // No row clear may still run once the block is idle.
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !clr_busy)
    else $error("row clear active while idle");

endmodule

`default_nettype wire

>>> tb/multi_pattern_byte_matcher_tb.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_tb
// Self-checking bench for the byte matcher: a directed table of commands,
// then random pattern sets, searches and noise under several idle profiles.
// Every result transfer is compared field by field with a trie model kept
// inside the bench, or with a fixed result for typed directed rows.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_byte_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpbm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic out_valid;
  in_t  in_item = '0;
  out_t out_item;

  multi_pattern_byte_matcher dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Trie model. Edge entries hold child index + 1; zero means no edge.
  logic [10:0] edge_mem [0:GOTO_DEPTH-1];
  logic [9:0]  fail_mem [0:MAX_NODES-1];
  bit          term_flag[0:MAX_NODES-1];
  logic [7:0]  term_id  [0:MAX_NODES-1];
  int          node_count;
  int          ins_node;
  int          scan_node;

  out_t expected_results[$];
  int   mismatches = 0;
  int   idle_pct = 0;

  function automatic int cap_node(int n);
    return (n >= 0 && n < MAX_NODES) ? n : 0;
  endfunction

  // Follow failure links until an edge on sym exists; give its target.
  function automatic int follow_fail(int node, int sym);
    int steps;
    steps = 0;
    node = cap_node(node);
    while (edge_mem[node*ALPHABET+sym] == 0) begin
      if (node == 0 || steps >= MAX_NODES) return 0;
      node = cap_node(fail_mem[node]);
      steps++;
    end
    return cap_node(int'(edge_mem[node*ALPHABET+sym]) - 1);
  endfunction

  task automatic build_fail_links();
    int bfs[$];
    int r, u, e;
    fail_mem[0] = '0;
    for (int a = 0; a < ALPHABET; a++) begin
      e = edge_mem[a];
      if (e == 0) begin
        edge_mem[a] = 11'd1;
      end else if (e != 1 && bfs.size() < MAX_NODES) begin
        fail_mem[cap_node(e-1)] = '0;
        bfs.push_back(cap_node(e-1));
      end
    end
    while (bfs.size() > 0) begin
      r = bfs.pop_front();
      for (int a = 0; a < ALPHABET; a++) begin
        e = edge_mem[r*ALPHABET+a];
        if (e == 0) continue;
        u = cap_node(e-1);
        if (u == 0) continue;
        bfs.push_back(u);
        fail_mem[u] = 10'(follow_fail(fail_mem[r], a));
      end
    end
  endtask

  // Advance the model by one command and give the result it causes.
  task automatic trie_step(input in_t it, output out_t res);
    int cur, e, n;
    bit ok;
    res = '0;
    case (it.kind)
      KIND_ADD: begin
        cur = cap_node(ins_node);
        ok = 1'b0;
        e = edge_mem[cur*ALPHABET+it.byte_value];
        if (e != 0 && cap_node(e-1) != 0) begin
          cur = cap_node(e-1);
          ok = 1'b1;
        end else if (node_count < MAX_NODES) begin
          n = node_count;
          for (int a = 0; a < ALPHABET; a++) edge_mem[n*ALPHABET+a] = '0;
          fail_mem[n] = '0;
          term_flag[n] = 1'b0;
          edge_mem[cur*ALPHABET+it.byte_value] = 11'(n + 1);
          node_count = n + 1;
          cur = n;
          ok = 1'b1;
        end else begin
          res.status = ST_FULL;
        end
        if (it.last_of_pattern) begin
          if (ok) begin
            if (term_flag[cur]) res.status = ST_REPL;
            term_flag[cur] = 1'b1;
            term_id[cur] = it.pattern_id;
          end
          cur = 0;
        end
        ins_node = cur;
        res.node_index = 10'(cur);
      end
      KIND_FIN: build_fail_links();
      KIND_BEGIN: scan_node = 0;
      default: begin
        cur = follow_fail(scan_node, it.byte_value);
        scan_node = cur;
        res.node_index = 10'(cur);
        if (term_flag[cur]) begin
          res.match = 1'b1;
          res.matched_id = term_id[cur];
        end
      end
    endcase
  endtask

  // Present one command, hold it until accepted, then idle gap cycles.
  task automatic xfer(input in_t it, input bit typed, input out_t typed_res);
    out_t res;
    int gap;
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    trie_step(it, res);
    expected_results.push_back(typed ? typed_res : res);
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send(input logic [1:0] k, input logic [7:0] b, input bit l,
                      input logic [7:0] id);
    in_t it;
    it.kind = k;
    it.byte_value = b;
    it.last_of_pattern = l;
    it.pattern_id = id;
    xfer(it, 1'b0, '0);
  endtask

  // Pause the sender until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() > 0);
  endtask

  // Mostly a four-symbol alphabet so patterns share prefixes and matches occur.
  function automatic logic [7:0] pick_sym();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 3));
  endfunction

  task automatic random_phase(input int n_items);
    int sent, len, sel;
    bit finalized;
    sent = 0;
    finalized = 1'b0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++)
          send(KIND_ADD, pick_sym(), i == len-1, 8'($urandom_range(0, 255)));
        sent += len;
      end else if (sel < 44 && !finalized) begin
        send(KIND_FIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             8'($urandom_range(0, 255)));
        finalized = 1'b1;
        sent++;
      end else if (sel < 54) begin
        send(KIND_BEGIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             8'($urandom_range(0, 255)));
        sent++;
      end else if (sel < 92) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          send(KIND_SCAN, pick_sym(), 1'($urandom_range(0, 1)),
               8'($urandom_range(0, 255)));
        sent += len;
      end else begin
        // noise: any command but finalize, fully random fields
        sel = $urandom_range(0, 2);
        send(sel == 0 ? KIND_ADD : (sel == 1 ? KIND_BEGIN : KIND_SCAN),
             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             8'($urandom_range(0, 255)));
        sent++;
      end
    end
    drain();
  endtask

  typedef struct {
    logic [1:0] kind;
    logic [7:0] byte_value;
    bit         last;
    logic [7:0] pid;
    bit         typed;
    out_t       res;
  } row_t;

  localparam out_t ZERO_RES = '0;

  // Directed commands; typed results only where they are plain to see.
  row_t directed_rows[] = '{
    '{KIND_SCAN,  8'h41, 1'b0, 8'h00, 1'b1, ZERO_RES},                  // scan before finalize
    '{KIND_BEGIN, 8'hFF, 1'b1, 8'hFF, 1'b1, ZERO_RES},
    '{KIND_ADD,   8'h00, 1'b0, 8'h00, 1'b1, '{1'b0, 8'h00, 10'd1, ST_OK}},
    '{KIND_ADD,   8'hFF, 1'b1, 8'hFF, 1'b1, ZERO_RES},
    '{KIND_ADD,   8'h00, 1'b1, 8'h01, 1'b1, ZERO_RES},
    '{KIND_ADD,   8'h00, 1'b1, 8'h02, 1'b1, '{1'b0, 8'h00, 10'd0, ST_REPL}}, // re-registration
    '{KIND_ADD,   8'hFF, 1'b1, 8'h00, 1'b0, ZERO_RES},
    '{KIND_ADD,   8'h01, 1'b0, 8'h00, 1'b0, ZERO_RES},
    '{KIND_ADD,   8'h02, 1'b1, 8'h80, 1'b0, ZERO_RES},
    '{KIND_ADD,   8'h02, 1'b1, 8'h55, 1'b0, ZERO_RES},
    '{KIND_FIN,   8'h00, 1'b0, 8'h00, 1'b1, ZERO_RES},
    '{KIND_BEGIN, 8'h00, 1'b0, 8'h00, 1'b1, ZERO_RES},
    '{KIND_SCAN,  8'h00, 1'b0, 8'h00, 1'b0, ZERO_RES},
    '{KIND_SCAN,  8'hFF, 1'b1, 8'hFF, 1'b0, ZERO_RES},
    '{KIND_SCAN,  8'h55, 1'b0, 8'h00, 1'b0, ZERO_RES},
    '{KIND_SCAN,  8'h01, 1'b0, 8'h00, 1'b0, ZERO_RES},
    '{KIND_SCAN,  8'h02, 1'b0, 8'h00, 1'b0, ZERO_RES},
    '{KIND_ADD,   8'h10, 1'b1, 8'h7F, 1'b0, ZERO_RES},                  // add after finalize
    '{KIND_FIN,   8'h00, 1'b0, 8'h00, 1'b1, ZERO_RES},                  // repeated finalize
    '{KIND_BEGIN, 8'h00, 1'b0, 8'h00, 1'b1, ZERO_RES},
    '{KIND_SCAN,  8'h10, 1'b0, 8'h00, 1'b0, ZERO_RES},
    '{KIND_SCAN,  8'h02, 1'b0, 8'h00, 1'b0, ZERO_RES}
  };

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: match=%0d id=%0h node=%0d status=%0d",
                   out_item.match, out_item.matched_id, out_item.node_index,
                   out_item.status);
      end else begin
        want = expected_results.pop_front();
        if (out_item.match !== want.match || out_item.matched_id !== want.matched_id ||
            out_item.node_index !== want.node_index || out_item.status !== want.status)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp match=%0d id=%0h node=%0d status=%0d, got match=%0d id=%0h node=%0d status=%0d",
                     want.match, want.matched_id, want.node_index, want.status,
                     out_item.match, out_item.matched_id, out_item.node_index,
                     out_item.status);
        end
      end
    end
  end

  initial begin
    in_t it;
    for (int i = 0; i < GOTO_DEPTH; i++) edge_mem[i] = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      fail_mem[i] = '0;
      term_flag[i] = 1'b0;
      term_id[i] = '0;
    end
    node_count = 1;
    ins_node = 0;
    scan_node = 0;

    // hold reset, then let the root row clear finish behind busy
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, no idling
    idle_pct = 0;
    foreach (directed_rows[i]) begin
      it.kind = directed_rows[i].kind;
      it.byte_value = directed_rows[i].byte_value;
      it.last_of_pattern = directed_rows[i].last;
      it.pattern_id = directed_rows[i].pid;
      xfer(it, directed_rows[i].typed, directed_rows[i].res);
    end
    drain();

    idle_pct = 0;
    random_phase(150);
    idle_pct = 82;
    random_phase(150);
    idle_pct = 32;
    random_phase(150);
    idle_pct = 0;
    random_phase(100);

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
